// ===== rtl/bchq_pkg.sv =====
// Shared types and constants of the button click and hold qualifier.
`default_nettype none

package bchq_pkg;

    localparam int BUTTONS   = 2;
    localparam int TIME_BITS = 32;

    localparam int OP_W    = 2;
    localparam int RAW_W   = 2;
    localparam int IDX_W   = 1;
    localparam int DELAY_W = 15;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] CLICK_MAX_RESET = 16'd500;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_HELD    = 2'd1,
        OP_CLICKED = 2'd2,
        OP_DOWN    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_CLICK_MAX = 2'd1
    } cfg_reg_t;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic              en;
        opcode_t           op;
        time_t             now;
        logic [DELAY_W-1:0] delay;
        logic [CFG_W-1:0]  debounce;
        logic [CFG_W-1:0]  click_max;
    } lane_cmd_t;

    typedef struct packed {
        logic level;
        logic answer;
    } lane_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bchq_if.sv =====
// Handshake channel interfaces for items, results and register writes.
`default_nettype none

interface bchq_req_if;
    import bchq_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [RAW_W-1:0]   raw_levels;
    logic [IDX_W-1:0]   button_index;
    logic [DELAY_W-1:0] hold_delay_ms;

    modport source (output valid, opcode, raw_levels, button_index, hold_delay_ms,
                    input ready);
    modport sink   (input valid, opcode, raw_levels, button_index, hold_delay_ms,
                    output ready);
endinterface

interface bchq_rsp_if;
    import bchq_pkg::*;
    logic             valid;
    logic             ready;
    logic             answer;
    logic [RAW_W-1:0] debounced_levels;

    modport source (output valid, answer, debounced_levels, input ready);
    modport sink   (input valid, answer, debounced_levels, output ready);
endinterface

interface bchq_cfg_if;
    import bchq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bchq_lane.sv =====
// Per-button debounce, click and hold state with its registered update.
`default_nettype none

module bchq_lane (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bchq_pkg::lane_cmd_t  cmd,
    input  wire logic                 raw,
    input  wire logic                 sel,
    output bchq_pkg::lane_rsp_t       rsp
);
    import bchq_pkg::*;

    logic  level_reg, level_next;
    time_t change_time_reg, change_time_next;
    logic  click_reg, click_next;
    logic  lock_reg, lock_next;
    time_t dt;
    logic  answer;

    always_comb
    begin
        level_next       = level_reg;
        change_time_next = change_time_reg;
        click_next       = click_reg;
        lock_next        = lock_reg;
        answer           = 1'b0;
        dt               = cmd.now - change_time_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                OP_TICK:
                begin
                    if ((raw != level_reg) && (dt > TIME_BITS'(cmd.debounce)))
                    begin
                        if (raw)
                        begin
                            lock_next = 1'b0;
                            if (dt < TIME_BITS'(cmd.click_max))
                            begin
                                click_next = 1'b1;
                            end
                        end
                        else
                        begin
                            click_next = 1'b0;
                        end
                        level_next       = raw;
                        change_time_next = cmd.now;
                    end
                end
                OP_HELD:
                begin
                    if (sel && (dt > TIME_BITS'(cmd.delay)) && !level_reg && !lock_reg)
                    begin
                        lock_next = 1'b1;
                        answer    = 1'b1;
                    end
                end
                OP_CLICKED:
                begin
                    if (sel && click_reg && !lock_reg)
                    begin
                        click_next = 1'b0;
                        answer     = 1'b1;
                    end
                end
                OP_DOWN:
                begin
                    answer = sel && !level_reg;
                end
                default:
                begin
                    answer = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b1;
            change_time_reg <= '0;
            click_reg       <= 1'b0;
            lock_reg        <= 1'b0;
        end
        else
        begin
            level_reg       <= level_next;
            change_time_reg <= change_time_next;
            click_reg       <= click_next;
            lock_reg        <= lock_next;
        end
    end

    assign rsp.level  = level_next;
    assign rsp.answer = answer;

    a_press_clears_click: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(level_reg)) |-> !click_reg)
        else $error("click flag survived an accepted press");

    a_tick_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.en && cmd.op == OP_TICK) |-> !answer)
        else $error("tick produced an answer");

    a_level_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg != $past(level_reg)) |-> (change_time_reg == $past(cmd.now)))
        else $error("accepted change without time stamp");

endmodule

`default_nettype wire

// ===== rtl/bchq_merge.sv =====
// Combine lane results and hold them in an output register with a skid stage.
`default_nettype none

module bchq_merge (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire bchq_pkg::lane_rsp_t lane_rsp [bchq_pkg::BUTTONS],
    output logic                     in_ready,
    bchq_rsp_if.source               rsp
);
    import bchq_pkg::*;

    logic             answer;
    logic [RAW_W-1:0] levels;
    logic             out_fire;

    logic             main_valid_reg;
    logic             main_answer_reg;
    logic [RAW_W-1:0] main_levels_reg;
    logic             skid_valid_reg;
    logic             skid_answer_reg;
    logic [RAW_W-1:0] skid_levels_reg;

    always_comb
    begin
        answer = 1'b0;
        levels = '0;
        for (int b = 0; b < BUTTONS; b++)
        begin
            answer    = answer | lane_rsp[b].answer;
            levels[b] = lane_rsp[b].level;
        end
    end

    assign out_fire = main_valid_reg && rsp.ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_answer_reg <= skid_answer_reg;
                main_levels_reg <= skid_levels_reg;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
            begin
                skid_answer_reg <= answer;
                skid_levels_reg <= levels;
            end
            else
            begin
                main_answer_reg <= answer;
                main_levels_reg <= levels;
            end
        end
    end

    assign rsp.valid            = main_valid_reg;
    assign rsp.answer           = main_answer_reg;
    assign rsp.debounced_levels = main_levels_reg;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds data ahead of main stage");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && main_valid_reg && !rsp.ready) |=> skid_valid_reg)
        else $error("stalled transfer was dropped");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rsp.ready) |=> (!skid_valid_reg && main_valid_reg))
        else $error("skid stage did not move to main stage");

endmodule

`default_nettype wire

// ===== rtl/button_click_hold_qualifier.sv =====
// Top level: debounced button click and hold qualifier with one lane per button.
// Each result is registered in the output register, or in the skid stage on a stall.
// Throughput: one item per cycle while the skid stage is empty; lanes update per item.
// Output side holds up to two results (output register plus skid stage) before req stalls.
// Reset: rst_n clears counter and lane state, buttons read released, registers 50 and 500.
`default_nettype none

module button_click_hold_qualifier (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bchq_req_if.sink   req,
    bchq_rsp_if.source rsp,
    bchq_cfg_if.sink   cfg
);
    import bchq_pkg::*;

    time_t            ms_now_reg;
    time_t            ms_inc_reg;
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] click_max_reg;
    logic             in_fire;
    logic             in_ready;
    logic             is_tick;
    lane_cmd_t        cmd;
    lane_rsp_t        lane_rsp [BUTTONS];

    assign in_fire   = req.valid && in_ready;
    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;
    assign is_tick   = (opcode_t'(req.opcode) == OP_TICK);

    always_comb
    begin
        cmd.en        = in_fire;
        cmd.op        = opcode_t'(req.opcode);
        cmd.now       = is_tick ? ms_inc_reg : ms_now_reg;
        cmd.delay     = req.hold_delay_ms;
        cmd.debounce  = debounce_reg;
        cmd.click_max = click_max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_now_reg <= '0;
            ms_inc_reg <= TIME_BITS'(1);
        end
        else if (in_fire && is_tick)
        begin
            ms_now_reg <= ms_inc_reg;
            ms_inc_reg <= ms_inc_reg + TIME_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            click_max_reg <= CLICK_MAX_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_DEBOUNCE:  debounce_reg  <= cfg.data;
                REG_CLICK_MAX: click_max_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_lane
        bchq_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .raw   (req.raw_levels[b]),
            .sel   (int'(req.button_index) == b),
            .rsp   (lane_rsp[b])
        );
    end

    bchq_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .lane_rsp (lane_rsp),
        .in_ready (in_ready),
        .rsp      (rsp)
    );

    a_inc_tracks_now: assert property (@(posedge clk) disable iff (!rst_n)
        ms_inc_reg == ms_now_reg + TIME_BITS'(1))
        else $error("counter pair out of step");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_tick) |=> (ms_now_reg == $past(ms_inc_reg)))
        else $error("tick did not advance the counter");

    a_query_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_tick) |=> $stable(ms_now_reg))
        else $error("query moved the counter");

endmodule

`default_nettype wire

// ===== bench/button_click_hold_qualifier_tb.sv =====
// Self-checking testbench for the button click and hold qualifier.
`default_nettype none

module button_click_hold_qualifier_tb;
    import bchq_pkg::*;

    typedef struct packed {
        opcode_t            op;
        logic [RAW_W-1:0]   raw;
        logic [IDX_W-1:0]   idx;
        logic [DELAY_W-1:0] delay;
    } press_item_t;

    typedef struct packed {
        logic             answer;
        logic [RAW_W-1:0] levels;
    } press_result_t;

    logic clk;
    logic rst_n;
    logic idle_mode;
    int   errors;

    bchq_req_if req_ch();
    bchq_rsp_if rsp_ch();
    bchq_cfg_if cfg_ch();

    button_click_hold_qualifier i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    time_t              now_ms;
    time_t              changed_at [BUTTONS];
    logic [BUTTONS-1:0] level_q;
    logic [BUTTONS-1:0] click_flag;
    logic [BUTTONS-1:0] hold_lock;
    logic [CFG_W-1:0]   debounce_q;
    logic [CFG_W-1:0]   click_max_q;

    press_result_t expected_results [$];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= !idle_mode || ($urandom_range(0, 99) >= 30);
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic qualify_item(input press_item_t it, output press_result_t res);
        time_t dt;
        logic  hit;
        hit = 1'b0;
        if (it.op == OP_TICK)
        begin
            now_ms = now_ms + 1;
            for (int b = 0; b < BUTTONS; b++)
            begin
                if (it.raw[b] != level_q[b])
                begin
                    dt = now_ms - changed_at[b];
                    if (dt > time_t'(debounce_q))
                    begin
                        if (it.raw[b])
                        begin
                            hold_lock[b] = 1'b0;
                            if (dt < time_t'(click_max_q))
                            begin
                                click_flag[b] = 1'b1;
                            end
                        end
                        else
                        begin
                            click_flag[b] = 1'b0;
                        end
                        level_q[b]    = it.raw[b];
                        changed_at[b] = now_ms;
                    end
                end
            end
        end
        else if (int'(it.idx) < BUTTONS)
        begin
            dt = now_ms - changed_at[it.idx];
            case (it.op)
                OP_HELD:
                begin
                    if (dt > time_t'(it.delay) && !level_q[it.idx] && !hold_lock[it.idx])
                    begin
                        hold_lock[it.idx] = 1'b1;
                        hit = 1'b1;
                    end
                end
                OP_CLICKED:
                begin
                    if (click_flag[it.idx] && !hold_lock[it.idx])
                    begin
                        click_flag[it.idx] = 1'b0;
                        hit = 1'b1;
                    end
                end
                default:
                begin
                    hit = !level_q[it.idx];
                end
            endcase
        end
        res.answer = hit;
        res.levels = level_q;
    endtask

    always @(posedge clk)
    begin
        press_item_t   it;
        press_result_t want_r;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_reg_t'(cfg_ch.index))
                    REG_DEBOUNCE:  debounce_q  = cfg_ch.data;
                    REG_CLICK_MAX: click_max_q = cfg_ch.data;
                    default:       ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
            begin
                it.op    = opcode_t'(req_ch.opcode);
                it.raw   = req_ch.raw_levels;
                it.idx   = req_ch.button_index;
                it.delay = req_ch.hold_delay_ms;
                qualify_item(it, want_r);
                expected_results.push_back(want_r);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected result: answer %0b levels %b",
                                         rsp_ch.answer, rsp_ch.debounced_levels));
                end
                else
                begin
                    want_r = expected_results.pop_front();
                    if (rsp_ch.answer !== want_r.answer)
                    begin
                        flag_error($sformatf("answer mismatch: expected %0b actual %0b",
                                             want_r.answer, rsp_ch.answer));
                    end
                    if (rsp_ch.debounced_levels !== want_r.levels)
                    begin
                        flag_error($sformatf("levels mismatch: expected %b actual %b",
                                             want_r.levels, rsp_ch.debounced_levels));
                    end
                end
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [RAW_W-1:0] raw,
                             input logic [IDX_W-1:0] idx, input logic [DELAY_W-1:0] delay);
        while (idle_mode && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.opcode        = op;
        req_ch.raw_levels    = raw;
        req_ch.button_index  = idx;
        req_ch.hold_delay_ms = delay;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = r;
        cfg_ch.data  = v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // drop valid, wait for every pending result, then let the pipeline empty
    task automatic settle();
        int w;
        req_ch.valid = 1'b0;
        for (w = 0; w < 1000 && expected_results.size() != 0; w++)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        send_item(OP_DOWN, 2'b11, 1'b0, 15'd0);
        send_item(OP_DOWN, 2'b11, 1'b1, 15'd0);
        send_item(OP_HELD, 2'b11, 1'b0, 15'd0);
        send_item(OP_CLICKED, 2'b11, 1'b1, 15'd32767);
        send_item(OP_TICK, 2'b00, 1'b0, 15'd0);
        send_item(OP_DOWN, 2'b00, 1'b0, 15'd0);
        send_item(OP_TICK, 2'b01, 1'b1, 15'd32767);
        send_item(OP_TICK, 2'b11, 1'b0, 15'd0);
        send_item(OP_HELD, 2'b00, 1'b1, 15'd32767);
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_CLICK_MAX, 16'hFFFF);
        send_item(OP_TICK, 2'b00, 1'b0, 15'd0);
        send_item(OP_HELD, 2'b00, 1'b0, 15'd0);
        send_item(OP_TICK, 2'b00, 1'b0, 15'd0);
        send_item(OP_HELD, 2'b00, 1'b0, 15'd0);
        send_item(OP_HELD, 2'b00, 1'b0, 15'd0);
        send_item(OP_CLICKED, 2'b00, 1'b0, 15'd0);
        send_item(OP_TICK, 2'b01, 1'b0, 15'd0);
        send_item(OP_CLICKED, 2'b01, 1'b0, 15'd0);
        send_item(OP_CLICKED, 2'b01, 1'b0, 15'd0);
        send_item(OP_HELD, 2'b01, 1'b1, 15'd32767);
        send_item(OP_DOWN, 2'b01, 1'b1, 15'd0);
        settle();
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        write_reg(REG_CLICK_MAX, 16'd0);
        send_item(OP_TICK, 2'b11, 1'b0, 15'd0);
        send_item(OP_TICK, 2'b10, 1'b1, 15'd0);
        send_item(OP_DOWN, 2'b10, 1'b1, 15'd0);
        settle();
        write_reg(REG_DEBOUNCE, 16'd0);
        send_item(OP_TICK, 2'b11, 1'b1, 15'd0);
        send_item(OP_CLICKED, 2'b11, 1'b1, 15'd0);
        settle();
    endtask

    // presses and releases with random spans, noisy samples and interleaved queries
    task automatic run_press_traffic(input int count, input int span_hi);
        logic [RAW_W-1:0]   want;
        logic [DELAY_W-1:0] delay;
        int                 left [BUTTONS];
        want = '1;
        for (int b = 0; b < BUTTONS; b++)
        begin
            left[b] = $urandom_range(0, span_hi);
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                delay = DELAY_W'($urandom_range(0, 32767));
            end
            else
            begin
                delay = DELAY_W'($urandom_range(0, span_hi));
            end
            if ($urandom_range(0, 99) < 55)
            begin
                for (int b = 0; b < BUTTONS; b++)
                begin
                    if (left[b] == 0)
                    begin
                        want[b] = ~want[b];
                        left[b] = $urandom_range(0, span_hi);
                    end
                    else
                    begin
                        left[b]--;
                    end
                end
                send_item(OP_TICK,
                          ($urandom_range(0, 9) == 0) ? RAW_W'($urandom) : want,
                          IDX_W'($urandom), delay);
            end
            else
            begin
                send_item(opcode_t'($urandom_range(1, 3)), RAW_W'($urandom),
                          IDX_W'($urandom), delay);
            end
        end
        settle();
    endtask

    task automatic test_random_sessions();
        int deb_set  [7] = '{0, 2, 5, 1, 3, 12, 65535};
        int clk_set  [7] = '{0, 8, 20, 65535, 3, 40, 0};
        int span_set [7] = '{4, 12, 30, 8, 10, 40, 20};
        int len_set  [7] = '{280, 280, 280, 260, 280, 280, 60};
        for (int s = 0; s < 7; s++)
        begin
            write_reg(REG_DEBOUNCE, CFG_W'(deb_set[s]));
            write_reg(REG_CLICK_MAX, CFG_W'(clk_set[s]));
            run_press_traffic(len_set[s], span_set[s]);
        end
    endtask

    task automatic test_steady_stream();
        idle_mode = 1'b0;
        write_reg(REG_DEBOUNCE, 16'd4);
        write_reg(REG_CLICK_MAX, 16'd15);
        run_press_traffic(220, 14);
        idle_mode = 1'b1;
    endtask

    initial
    begin
        errors               = 0;
        idle_mode            = 1'b1;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_TICK;
        req_ch.raw_levels    = '1;
        req_ch.button_index  = '0;
        req_ch.hold_delay_ms = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_DEBOUNCE;
        cfg_ch.data          = '0;
        now_ms               = '0;
        level_q              = '1;
        click_flag           = '0;
        hold_lock            = '0;
        debounce_q           = DEBOUNCE_RESET;
        click_max_q          = CLICK_MAX_RESET;
        for (int b = 0; b < BUTTONS; b++)
        begin
            changed_at[b] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_sessions();
        test_steady_stream();
        settle();

        if (expected_results.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (errors == 0)
        begin
            $display("button_click_hold_qualifier regression: pass");
        end
        else
        begin
            $display("button_click_hold_qualifier regression: fail");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("button_click_hold_qualifier regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
